// File: sv/qsup_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsup_pkg: shared types and constants of the quoted string unescape parser
// Holds the phase and result codes, the decoder state and result records,
// and the character constants used by the decoder.
// ----------------------------------------------------------------------------
package qsup_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 3;

    // Register map: the only register sits at byte address 0.
    localparam logic [APB_AW-1:0] ADDR_MAX_LENGTH = 3'd0;

    localparam logic [COUNT_W-1:0] MAX_LENGTH_RESET = 16'd256;

    localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRACK  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_LBRACE  = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE  = 8'h7D;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_FF      = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_BS      = 8'h08;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_LOW_N   = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_LOW_T   = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LOW_B   = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LOW_R   = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LOW_F   = 8'h66;

    typedef enum logic [1:0] {
        PH_SEEK = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_NUM  = 2'd3
    } t_phase;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE = 3'd0,
        KIND_BYTE = 3'd1,
        KIND_END  = 3'd2,
        KIND_SYN  = 3'd3,
        KIND_OVF  = 3'd4
    } t_kind;

    typedef struct packed {
        t_phase             phase;
        logic [BYTE_W-1:0]  number_value;
        logic               digit_seen;
        logic [COUNT_W-1:0] byte_count;
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [BYTE_W-1:0]  out_byte;
        logic [COUNT_W-1:0] decoded_count;
    } t_result;

    localparam t_state STATE_IDLE = '{
        phase:        PH_SEEK,
        number_value: '0,
        digit_seen:   1'b0,
        byte_count:   '0
    };

endpackage

// File: sv/qsup_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsup_if: valid/ready channels of the quoted string unescape parser
// The input channel carries raw bytes, the output channel decode results.
// ----------------------------------------------------------------------------
interface qsup_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface qsup_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  out_byte;
    logic [15:0] decoded_count;

    modport source (output valid, output kind, output out_byte, output decoded_count,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input decoded_count,
                    output ready);
endinterface

// File: sv/qsup_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsup_cfg: configuration register file
// APB-style slave holding the max_length register.
// ----------------------------------------------------------------------------
module qsup_cfg
    import qsup_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    output logic [COUNT_W-1:0] o_max_length
);

    logic [COUNT_W-1:0] r_max_length;
    logic               wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[APB_AW-1] == ADDR_MAX_LENGTH[APB_AW-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RESET;
        end else if (wr_hit) begin
            r_max_length <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1] == ADDR_MAX_LENGTH[APB_AW-1]) begin
            prdata = {{(APB_DW-COUNT_W){1'b0}}, r_max_length};
        end
    end

    assign o_max_length = r_max_length;

endmodule

// File: sv/qsup_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qsup_decode: single-byte decode step
// Combinational next state and result for one raw byte.
// ----------------------------------------------------------------------------
module qsup_decode
    import qsup_pkg::*;
(
    input  t_state             i_state,
    input  logic [BYTE_W-1:0]  i_byte,
    input  logic [COUNT_W-1:0] i_max_length,
    output t_state             o_state,
    output t_result            o_result
);

    logic               is_space;
    logic               is_digit;
    logic [BYTE_W-1:0]  digit_val;
    logic [COUNT_W:0]   cnt_plus1;
    logic [COUNT_W-1:0] cnt_next;
    logic               full;
    logic [BYTE_W-1:0]  times_ten;
    logic [BYTE_W-1:0]  esc_val;
    logic               esc_hit;

    assign is_space  = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
    assign is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit_val = i_byte - CH_ZERO;
    assign cnt_plus1 = {1'b0, i_state.byte_count} + {{COUNT_W{1'b0}}, 1'b1};
    assign cnt_next  = cnt_plus1[COUNT_W-1:0];
    assign full      = cnt_plus1 >= {1'b0, i_max_length};
    assign times_ten = {i_state.number_value[BYTE_W-4:0], 3'b000}
                     + {i_state.number_value[BYTE_W-2:0], 1'b0};

    always_comb begin
        esc_hit = 1'b1;
        esc_val = '0;
        unique case (i_byte)
            CH_LOW_N:  esc_val = CH_LF;
            CH_LOW_T:  esc_val = CH_TAB;
            CH_LOW_B:  esc_val = CH_BS;
            CH_LOW_R:  esc_val = CH_CR;
            CH_LOW_F:  esc_val = CH_FF;
            CH_BSLASH: esc_val = CH_BSLASH;
            CH_QUOTE:  esc_val = CH_QUOTE;
            CH_LBRACK: esc_val = CH_LBRACE;
            CH_RBRACK: esc_val = CH_RBRACE;
            default:   esc_hit = 1'b0;
        endcase
    end

    always_comb begin
        o_state                = i_state;
        o_result.kind          = KIND_NONE;
        o_result.out_byte      = '0;
        o_result.decoded_count = i_state.byte_count;

        unique case (i_state.phase)
            PH_SEEK: begin
                o_result.decoded_count = '0;
                if (i_byte == CH_QUOTE) begin
                    o_state            = STATE_IDLE;
                    o_state.phase      = PH_STR;
                end else if (!is_space) begin
                    o_state       = STATE_IDLE;
                    o_result.kind = KIND_SYN;
                end
            end
            PH_STR: begin
                if (i_byte == CH_QUOTE) begin
                    o_state       = STATE_IDLE;
                    o_result.kind = KIND_END;
                end else if (full) begin
                    o_state       = STATE_IDLE;
                    o_result.kind = KIND_OVF;
                end else if (i_byte == CH_BSLASH) begin
                    o_state.phase = PH_ESC;
                end else begin
                    o_state.byte_count     = cnt_next;
                    o_result.kind          = KIND_BYTE;
                    o_result.out_byte      = i_byte;
                    o_result.decoded_count = cnt_next;
                end
            end
            PH_ESC: begin
                if (esc_hit) begin
                    o_state.phase          = PH_STR;
                    o_state.byte_count     = cnt_next;
                    o_result.kind          = KIND_BYTE;
                    o_result.out_byte      = esc_val;
                    o_result.decoded_count = cnt_next;
                end else if (is_digit) begin
                    o_state.phase        = PH_NUM;
                    o_state.number_value = digit_val;
                    o_state.digit_seen   = 1'b1;
                end else begin
                    o_state       = STATE_IDLE;
                    o_result.kind = KIND_SYN;
                end
            end
            PH_NUM: begin
                if (is_digit) begin
                    o_state.number_value = times_ten + digit_val;
                    o_state.digit_seen   = 1'b1;
                end else if ((i_byte == CH_BSLASH) && i_state.digit_seen) begin
                    o_state.phase          = PH_STR;
                    o_state.number_value   = '0;
                    o_state.digit_seen     = 1'b0;
                    o_state.byte_count     = cnt_next;
                    o_result.kind          = KIND_BYTE;
                    o_result.out_byte      = i_state.number_value;
                    o_result.decoded_count = cnt_next;
                end else begin
                    o_state       = STATE_IDLE;
                    o_result.kind = KIND_SYN;
                end
            end
        endcase
    end

endmodule

// File: sv/quoted_string_unescape_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_unescape_parser: decoder for double-quoted, escaped strings
// Finds a quoted string in a byte stream, decodes its escapes and reports
// every decoded byte, the string end, syntax errors and buffer overflow.
// ----------------------------------------------------------------------------
// The block takes one raw byte per transaction on the input channel and gives
// exactly one result transaction for it on the output channel, in order. A
// byte is decoded in the cycle it is accepted: the parser state and a single
// output register are both loaded at that edge, so the sustained rate is one
// byte per clock cycle while the output is not stalled, and the result is
// offered from the cycle after acceptance. The input is ready whenever the
// output register is empty or its result is taken in the same cycle; only a
// stalled output holds off the input. The max_length register (byte address
// 0, reset 256) bounds the decoded length to max_length minus one bytes; it
// should be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module quoted_string_unescape_parser
    import qsup_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    qsup_in_if.sink           i_in,
    qsup_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [COUNT_W-1:0] max_length;
    t_state             r_state;
    t_state             n_state;
    t_result            r_result;
    t_result            n_result;
    logic               r_out_valid;
    logic               in_accept;

    // Configuration registers.
    qsup_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_max_length (max_length)
    );

    // One decode step from the current parser state and the offered byte.
    qsup_decode u_decode (
        .i_state      (r_state),
        .i_byte       (i_in.in_byte),
        .i_max_length (max_length),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // The output register frees up in the same cycle its result is taken,
    // which keeps the stream moving at one byte per cycle.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    // Parser state advances only on an accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_IDLE;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // The result payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_result.kind;
    assign o_out.out_byte      = r_result.out_byte;
    assign o_out.decoded_count = r_result.decoded_count;

    // Any terminating result must leave the parser idle with a cleared count.
    a_idle_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (n_result.kind == KIND_END || n_result.kind == KIND_SYN ||
                      n_result.kind == KIND_OVF)
        |=> (r_state.phase == PH_SEEK) && (r_state.byte_count == '0))
        else $error("parser not idle after string end or error");

    // A decoded byte advances the count by exactly one.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (n_result.kind == KIND_BYTE)
        |=> r_state.byte_count == $past(r_state.byte_count) + 16'd1)
        else $error("byte count did not advance by one on a decoded byte");

    // Number accumulator is only live inside a decimal escape.
    a_number_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.phase != PH_NUM)
        |-> (r_state.number_value == '0) && !r_state.digit_seen)
        else $error("number accumulator not cleared outside a decimal escape");

    // Only decoded-byte results carry a nonzero byte.
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_result.kind != KIND_BYTE) |-> (r_result.out_byte == '0))
        else $error("nonzero out_byte on a result that is not a decoded byte");

endmodule

// File: tb/sv/quoted_string_unescape_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_string_unescape_parser_tb: self-checking bench for the string decoder
// Drives raw bytes into the parser over its valid/ready input channel, follows
// every accepted byte with a shadow decoder kept in step with the max_length
// register, and compares each result transaction field by field in order.
// ----------------------------------------------------------------------------
module quoted_string_unescape_parser_tb;
    import qsup_pkg::*;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 11;
    // Far beyond the slowest legal run.
    localparam int WATCHDOG_NS  = 5_000_000;
    // The long output back-pressure stretch, in clock cycles.
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 175;
    localparam int NUM_PHASES   = 8;
    localparam int MAX_REPORTS  = 10;

    // The directed part is a table; a row either sends a byte, sends a byte whose
    // result is typed in by hand, or reprograms max_length.
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_FIXED,
        ROW_CFG
    } t_row_op;

    typedef struct {
        t_row_op       op;
        logic [15:0]   value;
        t_result       res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    qsup_in_if  in_ch ();
    qsup_out_if out_ch ();

    quoted_string_unescape_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Shadow copy of the decoder state and of the max_length register. Reset is
    // applied once at the start, so the declared values are the reset values.
    t_state       parser_state = STATE_IDLE;
    logic [15:0]  cfg_max_len  = MAX_LENGTH_RESET;

    // Decodes that have been accepted on the input but not yet seen on the output.
    t_result      pending_decodes [$];
    int           err_count = 0;

    // The byte on offer carries a hand-typed result when it comes from a
    // directed row that has one. These only change at the falling edge.
    bit           cur_fixed = 1'b0;
    t_result      cur_fixed_res;

    // Idling control, shared by the sender and the receiver processes.
    bit           idle_on = 1'b1;
    bit           hold_request = 1'b0;

    t_row         rows [$];
    logic [7:0]   seq_bytes [$];
    logic [15:0]  length_plan [NUM_PHASES] = '{
        16'd1, 16'd65535, 16'd2, 16'd7, 16'd0, 16'd23, 16'd4, 16'd256
    };

    // ------------------------------------------------------------------------
    // Shadow decoder: one raw byte in, one expected result out. It advances
    // parser_state exactly as the hardware is meant to.
    // ------------------------------------------------------------------------
    function automatic t_result decode_byte(input logic [7:0] c);
        t_result     res;
        logic [15:0] cnt;
        logic [7:0]  dec;
        logic        mapped;
        logic        is_digit;
        res      = '{kind: KIND_NONE, out_byte: 8'h00, decoded_count: 16'h0000};
        cnt      = parser_state.byte_count;
        dec      = 8'h00;
        mapped   = 1'b1;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        case (parser_state.phase)
            PH_SEEK: begin
                // Whitespace is space and the control range from tab to CR.
                if (c == CH_QUOTE) begin
                    parser_state.phase      = PH_STR;
                    parser_state.byte_count = '0;
                end else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
                    parser_state = STATE_IDLE;
                    res.kind     = KIND_SYN;
                end
            end
            PH_STR: begin
                res.decoded_count = cnt;
                if (c == CH_QUOTE) begin
                    parser_state = STATE_IDLE;
                    res.kind     = KIND_END;
                end else if ({1'b0, cnt} + 17'd1 >= {1'b0, cfg_max_len}) begin
                    // No room left for the terminator: the byte is dropped.
                    parser_state = STATE_IDLE;
                    res.kind     = KIND_OVF;
                end else if (c == CH_BSLASH) begin
                    parser_state.phase = PH_ESC;
                end else begin
                    parser_state.byte_count = cnt + 16'd1;
                    res = '{KIND_BYTE, c, cnt + 16'd1};
                end
            end
            PH_ESC: begin
                res.decoded_count = cnt;
                case (c)
                    CH_LOW_N:  dec = CH_LF;
                    CH_LOW_T:  dec = CH_TAB;
                    CH_LOW_B:  dec = CH_BS;
                    CH_LOW_R:  dec = CH_CR;
                    CH_LOW_F:  dec = CH_FF;
                    CH_BSLASH: dec = CH_BSLASH;
                    CH_QUOTE:  dec = CH_QUOTE;
                    CH_LBRACK: dec = CH_LBRACE;
                    CH_RBRACK: dec = CH_RBRACE;
                    default:   mapped = 1'b0;
                endcase
                if (mapped) begin
                    parser_state.phase      = PH_STR;
                    parser_state.byte_count = cnt + 16'd1;
                    res = '{KIND_BYTE, dec, cnt + 16'd1};
                end else if (is_digit) begin
                    parser_state.phase        = PH_NUM;
                    parser_state.number_value = c - CH_ZERO;
                    parser_state.digit_seen   = 1'b1;
                end else begin
                    parser_state = STATE_IDLE;
                    res.kind     = KIND_SYN;
                end
            end
            default: begin
                // Decimal number: the value wraps at eight bits.
                res.decoded_count = cnt;
                if (is_digit) begin
                    parser_state.number_value =
                        parser_state.number_value * 8'd10 + (c - CH_ZERO);
                    parser_state.digit_seen = 1'b1;
                end else if (c == CH_BSLASH && parser_state.digit_seen) begin
                    res = '{KIND_BYTE, parser_state.number_value, cnt + 16'd1};
                    parser_state.phase        = PH_STR;
                    parser_state.number_value = '0;
                    parser_state.digit_seen   = 1'b0;
                    parser_state.byte_count   = cnt + 16'd1;
                end else begin
                    parser_state = STATE_IDLE;
                    res.kind     = KIND_SYN;
                end
            end
        endcase
        return res;
    endfunction

    // The nine letters that may follow a backslash.
    function automatic logic [7:0] escape_letter(input int idx);
        case (idx)
            0:       return CH_LOW_N;
            1:       return CH_LOW_T;
            2:       return CH_LOW_B;
            3:       return CH_LOW_R;
            4:       return CH_LOW_F;
            5:       return CH_BSLASH;
            6:       return CH_QUOTE;
            7:       return CH_LBRACK;
            default: return CH_RBRACK;
        endcase
    endfunction

    // A byte that is neither a digit nor a valid escape letter, so it breaks
    // both an escape and a number. Uppercase letters, control codes and the
    // upper half of the byte range all qualify.
    function automatic logic [7:0] stray_byte();
        case ($urandom_range(0, 2))
            0:       return 8'($urandom_range(8'h41, 8'h5A));
            1:       return 8'($urandom_range(8'h00, 8'h1F));
            default: return 8'($urandom_range(8'h80, 8'hFF));
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard. Both channels are sampled at the rising edge. The output is
    // checked before the input is logged; a result can never belong to a byte
    // accepted at the same edge, so the front of the queue is always the
    // oldest outstanding decode.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result model_res;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_decodes.size() == 0) begin
                    note_mismatch($sformatf(
                        "result with nothing outstanding: kind %0d byte %02h count %0d",
                        out_ch.kind, out_ch.out_byte, out_ch.decoded_count));
                end else begin
                    want = pending_decodes.pop_front();
                    if (out_ch.kind !== want.kind || out_ch.out_byte !== want.out_byte ||
                        out_ch.decoded_count !== want.decoded_count) begin
                        note_mismatch($sformatf({
                            "result mismatch: expected kind %0d byte %02h count %0d, ",
                            "got kind %0d byte %02h count %0d"},
                            want.kind, want.out_byte, want.decoded_count,
                            out_ch.kind, out_ch.out_byte, out_ch.decoded_count));
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                // The shadow decoder always advances; a hand-typed row only
                // replaces what is expected on the output.
                model_res = decode_byte(in_ch.in_byte);
                pending_decodes.push_back(cur_fixed ? cur_fixed_res : model_res);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: holds ready low in random bursts while idling is on, and once
    // for a long stretch on request so that the output stalls and the block has
    // to push back on its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 10);
            end
            if (stall_left > 0 && i_rst_n) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= i_rst_n;
            end
        end
    end

    // Offers one byte and returns at the falling edge after it is accepted.
    // Called at a falling edge; valid stays high between back-to-back bytes.
    task automatic send_byte(input logic [7:0] b, input bit fixed, input t_result fixed_res);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        cur_fixed      = fixed;
        cur_fixed_res  = fixed_res;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every outstanding result is back, then lets
    // the output register settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        cur_fixed    = 1'b0;
        while (pending_decodes.size() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // One APB transfer to max_length: setup cycle, then access cycle until
    // pready. Called at a falling edge, returns at one.
    task automatic apb_access(input logic wr, input logic [15:0] data,
                              output logic [APB_DW-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_MAX_LENGTH;
        pwdata  <= {16'd0, data};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Reprograms max_length while the block is idle and reads it back. The bus
    // idles between the write and the read.
    task automatic set_max_length(input logic [15:0] value);
        logic [APB_DW-1:0] rd;
        wait_idle();
        apb_access(1'b1, value, rd);
        @(negedge i_clk);
        apb_access(1'b0, 16'd0, rd);
        if (rd[15:0] !== value) begin
            note_mismatch($sformatf("max_length readback: expected %0d, got %0d",
                                    value, rd[15:0]));
        end
        cfg_max_len = value;
    endtask

    task automatic row_byte(input logic [7:0] b);
        rows.push_back('{ROW_BYTE, {8'd0, b}, '{KIND_NONE, 8'h00, 16'd0}});
    endtask

    task automatic row_fixed(input logic [7:0] b, input t_kind k, input logic [7:0] ob,
                             input logic [15:0] cnt);
        rows.push_back('{ROW_FIXED, {8'd0, b}, '{k, ob, cnt}});
    endtask

    task automatic row_cfg(input logic [15:0] value);
        rows.push_back('{ROW_CFG, value, '{KIND_NONE, 8'h00, 16'd0}});
    endtask

    // ------------------------------------------------------------------------
    // Random traffic generator. Most sequences are well-formed strings with
    // random content: optional leading whitespace, an opening quote, a mix of
    // plain bytes, escapes and decimal numbers, then a closing quote. Some
    // strings are cut by a bad escape or a bad number byte, some are long
    // enough to overflow a small buffer, and the rest is raw noise.
    // ------------------------------------------------------------------------
    task automatic build_sequence();
        int         n;
        int         pick;
        logic [7:0] c;
        seq_bytes.delete();
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 3)) seq_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 2)) begin
            c = 8'($urandom_range(8, 13));
            seq_bytes.push_back(c == 8'd8 ? CH_SPACE : c);
        end
        seq_bytes.push_back(CH_QUOTE);
        // With a small buffer, now and then ask for more items than fit.
        if (cfg_max_len <= 16'd40 && $urandom_range(0, 4) == 0) begin
            n = int'(cfg_max_len) + $urandom_range(0, 2);
        end else begin
            n = $urandom_range(0, 8);
        end
        repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                do c = 8'($urandom_range(0, 255));
                while (c == CH_QUOTE || c == CH_BSLASH);
                seq_bytes.push_back(c);
            end else if (pick < 9) begin
                seq_bytes.push_back(CH_BSLASH);
                seq_bytes.push_back(escape_letter($urandom_range(0, 8)));
            end else begin
                seq_bytes.push_back(CH_BSLASH);
                repeat ($urandom_range(1, 4)) begin
                    seq_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                end
                seq_bytes.push_back(CH_BSLASH);
            end
        end
        case ($urandom_range(0, 9))
            0: begin
                seq_bytes.push_back(CH_BSLASH);
                seq_bytes.push_back(stray_byte());
            end
            1: begin
                seq_bytes.push_back(CH_BSLASH);
                seq_bytes.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
                seq_bytes.push_back($urandom_range(0, 3) == 0 ? CH_QUOTE : stray_byte());
            end
            default: seq_bytes.push_back(CH_QUOTE);
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed table, then random phases over a
    // spread of max_length settings, then drain and report.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int sent;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Straight after reset max_length is 256. A byte other than a quote or
        // whitespace before the string is a syntax error with a zero count.
        row_fixed(8'hFF, KIND_SYN, 8'h00, 16'd0);
        row_fixed(CH_QUOTE, KIND_NONE, 8'h00, 16'd0);
        row_fixed(8'hFF, KIND_BYTE, 8'hFF, 16'd1);
        // Every escape letter once, then a number that wraps: 259 gives 3.
        for (int i = 0; i < 9; i++) begin
            row_byte(CH_BSLASH);
            row_byte(escape_letter(i));
        end
        row_byte(CH_BSLASH);
        row_byte(8'h32);
        row_byte(8'h35);
        row_byte(8'h39);
        row_byte(CH_BSLASH);
        row_byte(CH_QUOTE);
        // An unknown escape letter and a non-digit inside a number both abort.
        row_byte(CH_QUOTE);
        row_byte(CH_BSLASH);
        row_fixed(8'h71, KIND_SYN, 8'h00, 16'd0);
        row_byte(CH_QUOTE);
        row_byte(CH_BSLASH);
        row_byte(8'h37);
        row_fixed(8'h78, KIND_SYN, 8'h00, 16'd0);
        // A buffer of three holds two bytes; the third overflows.
        row_cfg(16'd3);
        row_byte(CH_QUOTE);
        row_byte(8'h00);
        row_byte(8'h61);
        row_fixed(8'h62, KIND_OVF, 8'h00, 16'd2);
        // With a zero-sized buffer even an escape backslash overflows.
        row_cfg(16'd0);
        row_byte(CH_QUOTE);
        row_fixed(CH_BSLASH, KIND_OVF, 8'h00, 16'd0);
        row_cfg(16'd65535);
        row_byte(CH_QUOTE);
        row_byte(8'h7F);
        row_byte(CH_QUOTE);

        foreach (rows[k]) begin
            case (rows[k].op)
                ROW_CFG:   set_max_length(rows[k].value);
                ROW_FIXED: send_byte(rows[k].value[7:0], 1'b1, rows[k].res);
                default:   send_byte(rows[k].value[7:0], 1'b0, rows[k].res);
            endcase
        end

        // Random phases. Phase two runs without idling to give a stretch of
        // full-rate traffic, phase three opens with the long output stall, and
        // the last phase runs flat out on both sides.
        for (int p = 0; p < NUM_PHASES; p++) begin
            set_max_length(length_plan[p]);
            idle_on = !(p == 2 || p == NUM_PHASES - 1);
            if (p == 3) begin
                hold_request = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                build_sequence();
                foreach (seq_bytes[k]) begin
                    send_byte(seq_bytes[k], 1'b0, '{KIND_NONE, 8'h00, 16'd0});
                end
                sent += seq_bytes.size();
            end
        end

        wait_idle();
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("FAILURE");
        $finish;
    end

endmodule
